### design/meq_pkg.sv
// Shared defaults for the midpoint ellipse quadrant block.
package meq_pkg;

	localparam int DEF_RADIUS_BITS = 5;
	localparam int DEF_COORD_BITS  = 10;

endpackage

### design/midpoint_ellipse_quadrant_top.sv
// Top level of the midpoint ellipse quadrant walker.
// Usage:
//   Input channel (in_valid / in_stall) carries one draw command: centre
//   (center_x, center_y) and semi-axes (radius_x, radius_y). A transaction
//   completes at a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) carries one pixel per
//   transaction: pixel_x, pixel_y and last_pixel, set on the final pixel.
//   A zero y radius gives the lone centre pixel; a zero x radius gives the
//   vertical run from (0, ry) down to (0, 0).
// Walk sequence, with no output stalls:
//   Before region one, states SQX, SQY, RXRY and INIT work out the squared
//   radii and the start value on the one shared multiplier. Region one yields
//   one pixel per cycle and makes a final pass through R1, emitting nothing,
//   to see that it has ended; the switch to region two runs states M1 to M6
//   of multiplier work, and region two yields one pixel per cycle. A command
//   holds in_stall high from the moment it is taken until its last pixel is
//   loaded into the output register; the next command may set up while the
//   last pixel still waits.
// Reset and stalls: arst_n clears the sequencer and the output valid flag at
//   once. While out_stall holds a pixel, the walk freezes; nothing is lost.
module midpoint_ellipse_quadrant_top #(
	parameter int RADIUS_BITS = meq_pkg::DEF_RADIUS_BITS,
	parameter int COORD_BITS  = meq_pkg::DEF_COORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] center_x,
	input  logic [COORD_BITS-1:0] center_y,
	input  logic [RADIUS_BITS-1:0] radius_x,
	input  logic [RADIUS_BITS-1:0] radius_y,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_BITS:0]   pixel_x,
	output logic [COORD_BITS:0]   pixel_y,
	output logic                  last_pixel
);

	// widths: squared radius, step terms, multiplier operand, decision value
	localparam int R   = RADIUS_BITS;
	localparam int C   = COORD_BITS;
	localparam int SQW = 2 * R;
	localparam int DW  = 3 * R + 2;
	localparam int MW  = 2 * R + 3;
	localparam int W   = 2 * MW;
	localparam int KW  = R + 1;
	localparam int SW  = ((C > R + 1) ? C : R + 1) + 1;
	// a pixel is emitted from a loop only while fewer than 2^(R+1) - 2 are out
	localparam logic [KW-1:0] K_LIM = KW'((1 << (R + 1)) - 2);

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQX  = 4'd1;
	localparam logic [3:0] S_SQY  = 4'd2;
	localparam logic [3:0] S_RXRY = 4'd3;
	localparam logic [3:0] S_INIT = 4'd4;
	localparam logic [3:0] S_R1   = 4'd5;
	localparam logic [3:0] S_M1   = 4'd6;
	localparam logic [3:0] S_M2   = 4'd7;
	localparam logic [3:0] S_M3   = 4'd8;
	localparam logic [3:0] S_M4   = 4'd9;
	localparam logic [3:0] S_M5   = 4'd10;
	localparam logic [3:0] S_M6   = 4'd11;
	localparam logic [3:0] S_R2   = 4'd12;

	logic [3:0]     state_q;
	logic [C-1:0]   cx_q;
	logic [C-1:0]   cy_q;
	logic [R-1:0]   rx_q;
	logic [R-1:0]   ry_q;
	logic [SQW-1:0] rx2_q;
	logic [SQW-1:0] ry2_q;
	logic [R:0]     x_q;
	logic [R-1:0]   y_q;
	logic [DW-1:0]  dx_q;
	logic [DW-1:0]  dy_q;
	logic signed [W-1:0] d_q;
	logic [KW-1:0]  k_q;

	logic           out_valid_q;
	logic [C:0]     pixel_x_q;
	logic [C:0]     pixel_y_q;
	logic           last_q;

	logic [MW-1:0]  mul_a;
	logic [MW-1:0]  mul_b;
	logic [W-1:0]   prod;

	logic           accept;
	logic           slot_free;
	logic           r1_go;
	logic           r2_go;
	logic           emit;
	logic           emit_last;

	logic [DW-1:0]  dx_inc;
	logic [DW-1:0]  dy_dec;
	logic [DW-1:0]  dy_init;
	logic [R-1:0]   y_less;
	logic signed [W-1:0] s_prod;
	logic signed [W-1:0] s_dx_inc;
	logic signed [W-1:0] s_dy_dec;
	logic signed [W-1:0] s_rx2;
	logic signed [W-1:0] s_ry2;
	logic signed [W-1:0] d_init;
	logic signed [W-1:0] r1_d_lt;
	logic signed [W-1:0] r1_d_ge;
	logic signed [W-1:0] r2_d_ge;
	logic signed [W-1:0] r2_d_lt;
	logic [SW-1:0]  px_sum;
	logic [SW-1:0]  py_sum;

	meq_mul_unit #(
		.OPERAND_BITS(MW)
	) u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.product(prod)
	);

	// handshakes: hold off new commands for the whole walk
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign pixel_x    = pixel_x_q;
	assign pixel_y    = pixel_y_q;
	assign last_pixel = last_q;

	// loop conditions of both regions
	assign r1_go = (dx_q < dy_q) && (k_q < K_LIM);
	assign r2_go = (y_q != '0) && (k_q < K_LIM);

	// while the output slot is free, emit a pixel in region one while it steps, in region two always
	assign emit      = slot_free && (((state_q == S_R1) && r1_go) || (state_q == S_R2));
	assign emit_last = (state_q == S_R2) && !r2_go;

	// step terms and decision updates, decision values at four times nominal value
	assign dx_inc   = dx_q + (DW'(ry2_q) << 1);
	assign dy_dec   = dy_q - (DW'(rx2_q) << 1);
	assign dy_init  = DW'(prod) << 1;
	assign s_prod   = $signed(prod);
	assign s_dx_inc = $signed(W'(dx_inc));
	assign s_dy_dec = $signed(W'(dy_dec));
	assign s_rx2    = $signed(W'(rx2_q));
	assign s_ry2    = $signed(W'(ry2_q));
	assign d_init   = (s_ry2 <<< 2) - (s_prod <<< 2) + s_rx2;
	assign r1_d_lt  = d_q + ((s_dx_inc + s_ry2) <<< 2);
	assign r1_d_ge  = d_q + ((s_dx_inc - s_dy_dec + s_ry2) <<< 2);
	assign r2_d_ge  = d_q + ((s_rx2 - s_dy_dec) <<< 2);
	assign r2_d_lt  = d_q + ((s_dx_inc - s_dy_dec + s_rx2) <<< 2);

	// |y - 1| for the region-two start value; y is never negative
	assign y_less = (y_q == '0) ? R'(1) : (y_q - 1'b1);

	assign px_sum = SW'(cx_q) + SW'(x_q);
	assign py_sum = SW'(cy_q) + SW'(y_q);

	// steer the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQX: begin
				mul_a = MW'(rx_q);
				mul_b = MW'(rx_q);
			end
			S_SQY: begin
				mul_a = MW'(ry_q);
				mul_b = MW'(ry_q);
			end
			S_RXRY: begin
				mul_a = MW'(rx2_q);
				mul_b = MW'(ry_q);
			end
			S_M1: begin
				mul_a = MW'({x_q, 1'b1});
				mul_b = MW'({x_q, 1'b1});
			end
			S_M2: begin
				mul_a = MW'(ry2_q);
				mul_b = prod[MW-1:0];
			end
			S_M3: begin
				mul_a = MW'(y_less);
				mul_b = MW'(y_less);
			end
			S_M4: begin
				mul_a = MW'(rx2_q);
				mul_b = prod[MW-1:0];
			end
			S_M5: begin
				mul_a = MW'(rx2_q);
				mul_b = MW'(ry2_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// sequencer and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// drop the valid flag once the pixel is taken; a new pixel re-arms it
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SQX;
					end
				end
				S_SQX:  state_q <= S_SQY;
				S_SQY:  state_q <= S_RXRY;
				S_RXRY: state_q <= S_INIT;
				S_INIT: state_q <= S_R1;
				S_R1: begin
					if (!r1_go) begin
						state_q <= S_M1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: state_q <= S_M5;
				S_M5: state_q <= S_M6;
				S_M6: state_q <= S_R2;
				S_R2: begin
					if (slot_free && !r2_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cx_q <= center_x;
					cy_q <= center_y;
					rx_q <= radius_x;
					ry_q <= radius_y;
				end
			end
			S_SQY:  rx2_q <= prod[SQW-1:0];
			S_RXRY: ry2_q <= prod[SQW-1:0];
			S_INIT: begin
				x_q  <= '0;
				y_q  <= ry_q;
				dx_q <= '0;
				dy_q <= dy_init;
				d_q  <= d_init;
				k_q  <= '0;
			end
			S_R1: begin
				if (r1_go && slot_free) begin
					k_q  <= k_q + 1'b1;
					x_q  <= x_q + 1'b1;
					dx_q <= dx_inc;
					if (d_q[W-1]) begin
						d_q <= r1_d_lt;
					end else begin
						y_q  <= y_q - 1'b1;
						dy_q <= dy_dec;
						d_q  <= r1_d_ge;
					end
				end
			end
			S_M3: d_q <= s_prod;
			S_M5: d_q <= d_q + (s_prod <<< 2);
			S_M6: d_q <= d_q - (s_prod <<< 2);
			S_R2: begin
				if (r2_go && slot_free) begin
					k_q  <= k_q + 1'b1;
					y_q  <= y_q - 1'b1;
					dy_q <= dy_dec;
					if (!d_q[W-1]) begin
						d_q <= r2_d_ge;
					end else begin
						x_q  <= x_q + 1'b1;
						dx_q <= dx_inc;
						d_q  <= r2_d_lt;
					end
				end
			end
			default: ;
		endcase
	end

	// output register: load the current point, centre plus offset
	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x_q <= px_sum[C:0];
			pixel_y_q <= py_sum[C:0];
			last_q    <= emit_last;
		end
	end

endmodule

### design/meq_mul_unit.sv
// Shared unsigned multiplier with a registered product.
module meq_mul_unit #(
	parameter int OPERAND_BITS = 2 * meq_pkg::DEF_RADIUS_BITS + 3
) (
	input  logic                      clk,
	input  logic [OPERAND_BITS-1:0]   op_a,
	input  logic [OPERAND_BITS-1:0]   op_b,
	output logic [2*OPERAND_BITS-1:0] product
);

	logic [2*OPERAND_BITS-1:0] wide_a;
	logic [2*OPERAND_BITS-1:0] wide_b;

	assign wide_a = {{OPERAND_BITS{1'b0}}, op_a};
	assign wide_b = {{OPERAND_BITS{1'b0}}, op_b};

	// register the product; the sequencer picks it up in the state after the one that set the operands
	always_ff @(posedge clk) begin
		product <= wide_a * wide_b;
	end

endmodule

### verif/meq_pixel_checker.sv
`timescale 1ns / 1ps
// Pixel checker: predicts every quadrant walk and compares each output transaction against it.
module meq_pixel_checker #(
	parameter int RB = meq_pkg::DEF_RADIUS_BITS,
	parameter int CB = meq_pkg::DEF_COORD_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_stall,
	input  logic [CB-1:0] center_x,
	input  logic [CB-1:0] center_y,
	input  logic [RB-1:0] radius_x,
	input  logic [RB-1:0] radius_y,
	input  logic          out_valid,
	input  logic          out_stall,
	input  logic [CB:0]   pixel_x,
	input  logic [CB:0]   pixel_y,
	input  logic          last_pixel,
	output int            mismatch_count,
	output int            pixels_awaited,
	output int            commands_seen,
	output int            pixels_seen
);
	localparam int PIXEL_CAP = 2 * ((1 << RB) - 1) + 1;

	typedef struct packed {
		logic [CB:0] x;
		logic [CB:0] y;
		logic        last;
	} pixel_t;

	pixel_t awaited_pixels[$];

	// walk state, kept between commands as the block keeps it
	longint walk_x, walk_y, walk_d, span_x, span_y;

	task automatic report_mismatch(input string detail);
		$display("%0t ns: pixel %0d: %s", $time, pixels_seen, detail);
		mismatch_count++;
	endtask

	function automatic void queue_pixel(input logic [CB-1:0] cx, cy, input logic last);
		pixel_t p;
		p.x = cx + walk_x[CB:0];
		p.y = cy + walk_y[CB:0];
		p.last = last;
		awaited_pixels.push_back(p);
	endfunction

	// Two-region midpoint walk, decision values held at four times scale.
	function automatic void walk_quadrant(input logic [CB-1:0] cx, cy,
	                                      input logic [RB-1:0] rx, ry);
		longint a2, b2;
		int count;
		a2 = longint'(rx) * longint'(rx);
		b2 = longint'(ry) * longint'(ry);
		count = 0;
		walk_x = 0;
		walk_y = longint'(ry);
		span_x = 0;
		span_y = 2 * a2 * walk_y;
		walk_d = 4 * b2 - 4 * a2 * walk_y + a2;
		while (span_x < span_y && count < PIXEL_CAP - 1) begin
			queue_pixel(cx, cy, 1'b0);
			count++;
			walk_x++;
			span_x += 2 * b2;
			if (walk_d < 0)
				walk_d += 4 * (span_x + b2);
			else begin
				walk_y--;
				span_y -= 2 * a2;
				walk_d += 4 * (span_x - span_y + b2);
			end
		end
		walk_d = b2 * (2 * walk_x + 1) * (2 * walk_x + 1)
		       + 4 * a2 * (walk_y - 1) * (walk_y - 1) - 4 * a2 * b2;
		while (walk_y > 0 && count < PIXEL_CAP - 1) begin
			queue_pixel(cx, cy, 1'b0);
			count++;
			walk_y--;
			span_y -= 2 * a2;
			if (walk_d >= 0)
				walk_d += 4 * (a2 - span_y);
			else begin
				walk_x++;
				span_x += 2 * b2;
				walk_d += 4 * (span_x - span_y + a2);
			end
		end
		queue_pixel(cx, cy, 1'b1);
	endfunction

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				walk_quadrant(center_x, center_y, radius_x, radius_y);
				commands_seen++;
			end
			if (out_valid && !out_stall) begin
				if (awaited_pixels.size() == 0)
					report_mismatch($sformatf("(%0d, %0d) arrived with nothing awaited",
						pixel_x, pixel_y));
				else begin
					want = awaited_pixels.pop_front();
					if (pixel_x !== want.x)
						report_mismatch($sformatf("pixel_x %0d, expected %0d",
							pixel_x, want.x));
					if (pixel_y !== want.y)
						report_mismatch($sformatf("pixel_y %0d, expected %0d",
							pixel_y, want.y));
					if (last_pixel !== want.last)
						report_mismatch($sformatf("last_pixel %0b, expected %0b",
							last_pixel, want.last));
				end
				pixels_seen++;
			end
			pixels_awaited = awaited_pixels.size();
		end
	end

endmodule

### verif/midpoint_ellipse_quadrant_top_test.sv
`timescale 1ns / 1ps
// Testbench top: drives draw commands and output stalls around the quadrant walker.
module midpoint_ellipse_quadrant_top_test;
	import meq_pkg::*;

	localparam int RB = DEF_RADIUS_BITS;
	localparam int CB = DEF_COORD_BITS;
	localparam logic [RB-1:0] MAX_RADIUS = '1;
	localparam logic [CB-1:0] MAX_COORD = '1;
	localparam int RANDOM_COMMANDS = 192;
	// margin after the last awaited pixel, so stray output has a chance to show
	localparam int DRAIN_CYCLES = 100;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	logic [CB-1:0] center_x;
	logic [CB-1:0] center_y;
	logic [RB-1:0] radius_x;
	logic [RB-1:0] radius_y;
	logic          out_valid;
	logic          out_stall;
	logic [CB:0]   pixel_x;
	logic [CB:0]   pixel_y;
	logic          last_pixel;

	int   mismatch_count;
	int   pixels_awaited;
	int   commands_seen;
	int   pixels_seen;
	int   burst_left;
	int   directed_count;
	logic draining;

	midpoint_ellipse_quadrant_top #(
		.RADIUS_BITS(RB),
		.COORD_BITS (CB)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius_x  (radius_x),
		.radius_y  (radius_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.last_pixel(last_pixel)
	);

	// The checker sits beside the block, watching both channels on its own.
	meq_pixel_checker #(
		.RB(RB),
		.CB(CB)
	) pixel_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.center_x      (center_x),
		.center_y      (center_y),
		.radius_x      (radius_x),
		.radius_y      (radius_y),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.last_pixel    (last_pixel),
		.mismatch_count(mismatch_count),
		.pixels_awaited(pixels_awaited),
		.commands_seen (commands_seen),
		.pixels_seen   (pixels_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one draw command and hold it until the block takes the transaction.
	// Commands come in bursts; between most bursts, drop valid for a random gap.
	task automatic issue_command(input logic [CB-1:0] cx, cy, input logic [RB-1:0] rx, ry);
		int gap;
		if (burst_left == 0) begin
			// a quarter of the bursts run straight on with no gap at all
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		center_x <= cx;
		center_y <= cy;
		radius_x <= rx;
		radius_y <= ry;
		// hold the payload steady until a rising edge with stall low
		do @(posedge clk); while (in_stall);
	endtask

	// Pick a coordinate, leaning now and then on the two ends of the range.
	function automatic logic [CB-1:0] pick_coord();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return MAX_COORD;
			default: return CB'($urandom_range(0, MAX_COORD));
		endcase
	endfunction

	// Pick a radius; zero and full scale each turn up often enough to matter.
	function automatic logic [RB-1:0] pick_radius();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return MAX_RADIUS;
			2:       return RB'($urandom_range(1, 3));
			default: return RB'($urandom_range(0, MAX_RADIUS));
		endcase
	endfunction

	// Receiver: switch between stall patterns every so often, from never stalling to
	// stalling most cycles. Force stall low during the final drain so nothing hides.
	initial begin
		int mode;
		int span;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 120);
			repeat (span) begin
				@(negedge clk);
				if (draining)
					out_stall <= 1'b0;
				else case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 3) == 0);
					2:       out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Sender and verdict.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		center_x = '0;
		center_y = '0;
		radius_x = '0;
		radius_y = '0;
		draining = 1'b0;
		burst_left = 0;
		repeat (10) @(posedge clk);
		// release reset away from the active edge
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// Directed part: both radii at zero (lone centre pixel), zero y radius,
		// zero x radius (straight vertical run), full radii, unit radii, tall and
		// wide shapes, and centres at both ends so the pixel sums carry into bit 10.
		issue_command(0, 0, 0, 0);
		issue_command(MAX_COORD, MAX_COORD, MAX_RADIUS, MAX_RADIUS);
		issue_command(MAX_COORD, 0, MAX_RADIUS, 0);
		issue_command(0, MAX_COORD, 0, MAX_RADIUS);
		issue_command(512, 512, 0, 0);
		issue_command(MAX_COORD, MAX_COORD, 0, 0);
		issue_command(100, 200, 1, 1);
		issue_command(5, 7, MAX_RADIUS, 1);
		issue_command(9, 3, 1, MAX_RADIUS);
		issue_command(300, 400, 0, 1);
		issue_command(300, 400, 1, 0);
		issue_command(700, 50, 5, 3);
		issue_command(50, 700, 3, 5);
		issue_command(MAX_COORD - 1'b1, 1, 2, 2);
		issue_command(0, 0, MAX_RADIUS, MAX_RADIUS);
		issue_command(341, 682, 21, 10);
		issue_command(682, 341, 10, 21);
		issue_command(MAX_COORD, 512, MAX_RADIUS, MAX_RADIUS - 1'b1);
		directed_count = 18;

		// Random part: every field over its whole range, bursts of back-to-back
		// commands so a new one sets up while the last pixel still waits.
		repeat (RANDOM_COMMANDS)
			issue_command(pick_coord(), pick_coord(), pick_radius(), pick_radius());

		@(negedge clk);
		in_valid <= 1'b0;
		draining <= 1'b1;
		// wait for every predicted pixel, then give stray output a chance to show
		wait (pixels_awaited == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Walked %0d quadrants (%0d directed, radii 0 to %0d, centres 0 to %0d)",
			commands_seen, directed_count, MAX_RADIUS, MAX_COORD);
		$display("Compared %0d pixels under bursty input and mixed output stalls",
			pixels_seen);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run with the heaviest stalls.
	initial begin
		#6000000;
		$display("Timed out with %0d pixels still awaited", pixels_awaited);
		$display("Mismatches found");
		$finish;
	end

endmodule
